@@ rtl/modular_exponentiation_macros.svh @@
// Assertion macros for the modular exponentiation controller.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication.
`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MEXP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mexp_pkg.sv @@
`default_nettype none

package mexp_pkg;

	localparam int unsigned FIELD_BITS           = 32;
	localparam int unsigned OPERAND_BITS_DEFAULT = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_DONE
	} mexp_state_t;

	// Multiplicand of the bit-serial modular multiplier.
	typedef enum logic [1:0] {
		MCAND_ONE,
		MCAND_ACC,
		MCAND_BASE
	} mexp_mcand_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] base_value;
		logic [FIELD_BITS-1:0] exponent_value;
		logic [FIELD_BITS-1:0] modulus_value;
	} mexp_req_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] power_residue;
	} mexp_rsp_t;

	typedef struct packed {
		logic        load;
		logic        mul_start;
		logic        mul_step;
		mexp_mcand_t mcand_sel;
		logic        base_write;
		logic        acc_write;
		logic        exp_shift;
		logic        res_write;
	} mexp_cmd_t;

	typedef struct packed {
		logic in_exp_zero;
		logic in_mod_zero;
		logic exp_msb;
	} mexp_status_t;

endpackage

`default_nettype wire

@@ rtl/mexp_stream_if.sv @@
`default_nettype none

interface mexp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/mexp_datapath.sv @@
`default_nettype none

module mexp_datapath #(
	parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
	input  wire                 clk,
	input  mexp_pkg::mexp_cmd_t cmd,
	input  mexp_pkg::mexp_req_t in_data,
	output mexp_pkg::mexp_status_t status,
	output mexp_pkg::mexp_rsp_t out_data
);

	localparam logic [OPERAND_BITS-1:0] ONE = OPERAND_BITS'(1);

	logic [OPERAND_BITS-1:0] b_in;
	logic [OPERAND_BITS-1:0] e_in;
	logic [OPERAND_BITS-1:0] m_in;

	logic [OPERAND_BITS-1:0] mod_q;
	logic [OPERAND_BITS-1:0] exp_q;
	logic [OPERAND_BITS-1:0] mplier_q;
	logic [OPERAND_BITS-1:0] prod_q;
	logic [OPERAND_BITS-1:0] acc_q;
	logic [OPERAND_BITS-1:0] base_q;
	logic [mexp_pkg::FIELD_BITS-1:0] res_q;

	logic [OPERAND_BITS-1:0] mcand;
	logic [OPERAND_BITS-1:0] dbl;
	logic [OPERAND_BITS-1:0] prod_next;

	// (a + b) mod m for a, b below m. The plain sum is only taken when it stays below m,
	// so it never leaves the operand width.
	function automatic logic [OPERAND_BITS-1:0] add_mod(
		input logic [OPERAND_BITS-1:0] a,
		input logic [OPERAND_BITS-1:0] b,
		input logic [OPERAND_BITS-1:0] m
	);
		logic [OPERAND_BITS-1:0] gap;
		gap = m - b;
		return (a >= gap) ? (a - gap) : (a + b);
	endfunction

	assign b_in = OPERAND_BITS'(in_data.base_value);
	assign e_in = OPERAND_BITS'(in_data.exponent_value);
	assign m_in = OPERAND_BITS'(in_data.modulus_value);

	assign status.in_exp_zero = (e_in == '0);
	assign status.in_mod_zero = (m_in == '0);
	assign status.exp_msb     = exp_q[OPERAND_BITS-1];

	always_comb begin
		case (cmd.mcand_sel)
			mexp_pkg::MCAND_ONE:  mcand = ONE;
			mexp_pkg::MCAND_ACC:  mcand = acc_q;
			mexp_pkg::MCAND_BASE: mcand = base_q;
			default:              mcand = ONE;
		endcase
	end

	// One multiplier bit per cycle, MSB first: double, then add the multiplicand if the bit is 1.
	// With a multiplicand of one this is a plain restoring remainder of the multiplier.
	assign dbl       = add_mod(prod_q, prod_q, mod_q);
	assign prod_next = mplier_q[OPERAND_BITS-1] ? add_mod(dbl, mcand, mod_q) : dbl;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mod_q    <= m_in;
			exp_q    <= e_in;
			mplier_q <= b_in;
			prod_q   <= '0;
			if (e_in == '0) begin
				acc_q <= ONE;
			end else if (m_in <= ONE) begin
				acc_q <= '0;
			end else begin
				acc_q <= ONE;
			end
		end
		if (cmd.mul_start) begin
			prod_q   <= '0;
			mplier_q <= acc_q;
		end
		if (cmd.mul_step) begin
			prod_q   <= prod_next;
			mplier_q <= mplier_q << 1;
		end
		if (cmd.base_write) begin
			base_q <= prod_next;
		end
		if (cmd.acc_write) begin
			acc_q <= prod_next;
		end
		if (cmd.exp_shift) begin
			exp_q <= exp_q << 1;
		end
		if (cmd.res_write) begin
			res_q <= mexp_pkg::FIELD_BITS'(acc_q);
		end
	end

	assign out_data.power_residue = res_q;

endmodule

`default_nettype wire

@@ rtl/mexp_ctrl.sv @@
`default_nettype none

`include "modular_exponentiation_macros.svh"

module mexp_ctrl #(
	parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire                    out_ready,
	input  mexp_pkg::mexp_status_t status,
	output mexp_pkg::mexp_cmd_t    cmd
);

	localparam int unsigned STEP_W = $clog2(OPERAND_BITS + 1);
	localparam int unsigned EBIT_W = $clog2(OPERAND_BITS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(OPERAND_BITS);
	localparam logic [EBIT_W-1:0] EBIT_LAST = EBIT_W'(OPERAND_BITS - 1);

	mexp_pkg::mexp_state_t state_q, state_d;
	logic [STEP_W-1:0] step_cnt_q, step_cnt_d;
	logic [EBIT_W-1:0] ebit_cnt_q, ebit_cnt_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			step_cnt_q  <= '0;
			ebit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			step_cnt_q <= step_cnt_d;
			ebit_cnt_q <= ebit_cnt_d;
			if (cmd.res_write) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		step_cnt_d    = step_cnt_q;
		ebit_cnt_d    = ebit_cnt_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.mcand_sel = mexp_pkg::MCAND_ONE;

		case (state_q)
			mexp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					step_cnt_d = STEP_W'(1);
					ebit_cnt_d = '0;
					if (status.in_exp_zero || status.in_mod_zero) begin
						state_d = mexp_pkg::ST_DONE;
					end else begin
						state_d = mexp_pkg::ST_REDUCE;
					end
				end
			end
			mexp_pkg::ST_REDUCE: begin
				cmd.mul_step = 1'b1;
				step_cnt_d   = step_cnt_q + STEP_W'(1);
				if (step_cnt_q == STEP_LAST) begin
					cmd.base_write = 1'b1;
					step_cnt_d     = '0;
					state_d        = mexp_pkg::ST_SQUARE;
				end
			end
			mexp_pkg::ST_SQUARE: begin
				cmd.mcand_sel = mexp_pkg::MCAND_ACC;
				if (step_cnt_q == '0) begin
					cmd.mul_start = 1'b1;
					step_cnt_d    = STEP_W'(1);
				end else begin
					cmd.mul_step = 1'b1;
					step_cnt_d   = step_cnt_q + STEP_W'(1);
					if (step_cnt_q == STEP_LAST) begin
						cmd.acc_write = 1'b1;
						step_cnt_d    = '0;
						if (status.exp_msb) begin
							state_d = mexp_pkg::ST_MULT;
						end else begin
							cmd.exp_shift = 1'b1;
							if (ebit_cnt_q == EBIT_LAST) begin
								state_d = mexp_pkg::ST_DONE;
							end else begin
								ebit_cnt_d = ebit_cnt_q + EBIT_W'(1);
							end
						end
					end
				end
			end
			mexp_pkg::ST_MULT: begin
				cmd.mcand_sel = mexp_pkg::MCAND_BASE;
				if (step_cnt_q == '0) begin
					cmd.mul_start = 1'b1;
					step_cnt_d    = STEP_W'(1);
				end else begin
					cmd.mul_step = 1'b1;
					step_cnt_d   = step_cnt_q + STEP_W'(1);
					if (step_cnt_q == STEP_LAST) begin
						cmd.acc_write = 1'b1;
						cmd.exp_shift = 1'b1;
						step_cnt_d    = '0;
						if (ebit_cnt_q == EBIT_LAST) begin
							state_d = mexp_pkg::ST_DONE;
						end else begin
							ebit_cnt_d = ebit_cnt_q + EBIT_W'(1);
							state_d    = mexp_pkg::ST_SQUARE;
						end
					end
				end
			end
			mexp_pkg::ST_DONE: begin
				// The result moves to the output register once the previous beat has left.
				if (out_free) begin
					cmd.res_write = 1'b1;
					state_d       = mexp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	`MEXP_ASSERT_IMP(a_res_no_overwrite, cmd.res_write && out_valid_q, out_ready, "pending result overwritten")
	`MEXP_ASSERT_IMP(a_step_bound, 1'b1, step_cnt_q <= STEP_LAST, "step counter out of range")
	`MEXP_ASSERT_NXT(a_trivial_short, in_valid && in_ready && (status.in_exp_zero || status.in_mod_zero), state_q == mexp_pkg::ST_DONE, "trivial item did not skip the multiplier")
	`MEXP_ASSERT_NXT(a_ebit_hold, cmd.mul_step && (step_cnt_q != STEP_LAST), $stable(ebit_cnt_q), "exponent bit advanced mid-multiplication")

endmodule

`default_nettype wire

@@ rtl/modular_exponentiation.sv @@
// Modular exponentiation, base ** exponent mod modulus, by left-to-right square and multiply.
// One result beat follows each request beat. A zero exponent gives 1 for every modulus, and a
// zero modulus with a nonzero exponent gives 0; both skip the multiplier and go straight to the
// done state. Every other item uses the single bit-serial modular multiplier, which handles
// one multiplier bit per cycle and serves the initial base reduction, every squaring and
// every multiplication in turn.
// One item is worked on at a time; a new request is taken while the previous result still
// waits in the output register.
`default_nettype none

module modular_exponentiation #(
	parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
	input wire             clk,
	input wire             arst_n,
	mexp_stream_if.sink    req,
	mexp_stream_if.source  rsp
);

	mexp_pkg::mexp_cmd_t    cmd;
	mexp_pkg::mexp_status_t status;
	mexp_pkg::mexp_rsp_t    res;

	mexp_ctrl #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mexp_datapath #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.in_data  (req.payload),
		.status   (status),
		.out_data (res)
	);

	assign rsp.payload = res;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned RANDOM_ITEMS    = 258;
	localparam int unsigned HOLD_OFF_CYCLES = 6000;
	localparam int unsigned DRAIN_CYCLES    = 2400;
	localparam int unsigned DIRECTED_ROWS   = 22;

	typedef logic [mexp_pkg::FIELD_BITS-1:0] word_t;

	typedef struct {
		word_t base_value;
		word_t exponent_value;
		word_t modulus_value;
		word_t residue;
		bit    known;
	} directed_row_t;

	typedef struct {
		mexp_pkg::mexp_req_t request;
		word_t               residue;
	} pending_residue_t;

	logic clk = 1'b0;
	logic arst_n;

	mexp_stream_if #(.payload_t(mexp_pkg::mexp_req_t)) req_if ();
	mexp_stream_if #(.payload_t(mexp_pkg::mexp_rsp_t)) rsp_if ();

	modular_exponentiation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	pending_residue_t expected_residues [$];
	directed_row_t    directed_rows [DIRECTED_ROWS];
	int unsigned      error_count = 0;
	int unsigned      sender_idle_pct = 30;
	int unsigned      receiver_idle_pct = 67;
	int unsigned      hold_off_requests = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#60_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Left-to-right square and multiply with every product kept at double width.
	function automatic word_t power_residue_of(input word_t b, input word_t e, input word_t m);
		logic [2*mexp_pkg::FIELD_BITS-1:0] acc;
		logic [2*mexp_pkg::FIELD_BITS-1:0] rb;
		if (e == '0)
			return word_t'(1);
		acc = 64'd1 % m;
		rb  = b % m;
		for (int i = mexp_pkg::FIELD_BITS - 1; i >= 0; i--) begin
			acc = (acc * acc) % m;
			if (e[i])
				acc = (acc * rb) % m;
		end
		return acc[mexp_pkg::FIELD_BITS-1:0];
	endfunction

	function automatic mexp_pkg::mexp_req_t random_request();
		mexp_pkg::mexp_req_t item;
		word_t               m;
		case ($urandom_range(9))
			0: m = 32'd1;
			1: m = $urandom_range(2, 255);
			2: m = 32'd1 << $urandom_range(31);
			3: m = {1'b1, 31'($urandom)};
			4: m = 32'hFFFF_FFFF - $urandom_range(15);
			default: begin
				m = $urandom;
				if (m == '0)
					m = 32'd1;
			end
		endcase
		item.modulus_value = m;
		case ($urandom_range(9))
			0: item.exponent_value = '0;
			1: item.exponent_value = $urandom_range(1, 16);
			2: item.exponent_value = 32'hFFFF_FFFF;
			3: item.exponent_value = 32'd1 << $urandom_range(31);
			default: item.exponent_value = $urandom;
		endcase
		case ($urandom_range(7))
			0: item.base_value = '0;
			1: item.base_value = m;
			2: item.base_value = m - 32'd1;
			3: item.base_value = $urandom_range(3);
			default: item.base_value = $urandom;
		endcase
		return item;
	endfunction

	// Entered and left at a rising edge. The handshake is sampled at the falling edge,
	// where both sides are settled, and the beat counts at the following rising edge.
	task automatic send_request(input mexp_pkg::mexp_req_t item, input word_t residue);
		bit taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= item;
		do begin
			@(negedge clk);
			taken = req_if.ready;
			if (taken)
				expected_residues.push_back('{request: item, residue: residue});
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_for_drain();
		req_if.valid <= 1'b0;
		while (expected_residues.size() != 0)
			@(posedge clk);
	endtask

	initial begin : receiver
		int unsigned served;
		int unsigned left;
		served = 0;
		left   = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (served != hold_off_requests) begin
				served = hold_off_requests;
				left   = HOLD_OFF_CYCLES;
			end
			if (left != 0) begin
				left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	always @(negedge clk) begin
		pending_residue_t head;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_residues.size() == 0) begin
				report_mismatch($sformatf("result beat %h with nothing outstanding",
					rsp_if.payload.power_residue));
			end else begin
				head = expected_residues.pop_front();
				if (rsp_if.payload.power_residue !== head.residue)
					report_mismatch($sformatf("%h ** %h mod %h: power_residue %h, want %h",
						head.request.base_value, head.request.exponent_value,
						head.request.modulus_value, rsp_if.payload.power_residue,
						head.residue));
			end
		end
	end

	initial begin : stimulus
		mexp_pkg::mexp_req_t item;
		word_t               residue;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;

		// Rows with a typed residue are read off by hand; the rest go through the predictor.
		directed_rows = '{
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 1'b1},
			'{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1},
			'{32'h0000_3039, 32'h0000_0000, 32'h0000_0007, 32'h0000_0001, 1'b1},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b1},
			'{32'h0000_0005, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b1},
			'{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
			'{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1},
			'{32'h0000_0005, 32'h0000_0001, 32'h0000_0007, 32'h0000_0005, 1'b1},
			'{32'h0000_0002, 32'h0000_000A, 32'hFFFF_FFFF, 32'h0000_0400, 1'b1},
			'{32'h0000_0003, 32'h0000_0004, 32'h0000_03E8, 32'h0000_0051, 1'b1},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
			'{32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1},
			'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1},
			'{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0001, 1'b1},
			'{32'h1234_5678, 32'h0000_0001, 32'h0000_0002, 32'h0000_0000, 1'b1},
			'{32'h0000_0007, 32'h0000_0002, 32'h0000_0002, 32'h0000_0001, 1'b1},
			'{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFB, 32'h0000_0000, 1'b0},
			'{32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0},
			'{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
			'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB, 32'h0000_0000, 1'b0},
			'{32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h0000_0000, 1'b0},
			'{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0003, 32'h0000_0000, 1'b0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			item.base_value     = directed_rows[i].base_value;
			item.exponent_value = directed_rows[i].exponent_value;
			item.modulus_value  = directed_rows[i].modulus_value;
			residue = directed_rows[i].known ? directed_rows[i].residue :
				power_residue_of(item.base_value, item.exponent_value, item.modulus_value);
			send_request(item, residue);
		end

		// Stall the result side for long enough that the block fills and refuses beats.
		hold_off_requests <= hold_off_requests + 1;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				wait_for_drain();
				sender_idle_pct   = 67;
				receiver_idle_pct <= 30;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				wait_for_drain();
				sender_idle_pct   = 0;
				receiver_idle_pct <= 0;
			end
			item = random_request();
			send_request(item,
				power_residue_of(item.base_value, item.exponent_value, item.modulus_value));
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_stream_if.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
verif/tb_top.sv
